// File: hw/rtl/cdtgs_pkg.sv
// Shared constants, types and the control state encoding of the CDT Gaussian sampler.
// No dependencies; every other file of the block imports this package.
package cdtgs_pkg;

   localparam int MAX_HALF_WIDTH = 64;
   localparam int TABLE_DEPTH    = 2 * MAX_HALF_WIDTH + 1;
   localparam int WORD_W         = 64;
   localparam int HW_W           = 7;
   localparam int IDX_W          = 8;
   localparam int CNT_W          = $clog2(TABLE_DEPTH);
   localparam int DIFF_W         = CNT_W + 1;
   localparam int CSR_IDX_W      = 1;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [CNT_W-1:0]  cell_index_type;
   typedef logic [HW_W-1:0]   half_width_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULUS    = 1'b0,
      CSR_HALF_WIDTH = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   localparam cell_index_type LAST_STEP = cell_index_type'(TABLE_DEPTH - 1);

   // Control handed from the sequencer to the row of table cells.
   typedef struct packed {
      logic           shift;
      logic           load;
      cell_index_type load_index;
   } chain_ctl_type;

endpackage

// File: hw/rtl/cdtgs_cell.sv
// One table cell: holds a single CDF word, takes a load or its neighbor's word.
// Depends on cdtgs_pkg.
module cdtgs_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  logic              load_en,
   input  cdtgs_pkg::word_type load_value,
   input  cdtgs_pkg::word_type next_value,
   output cdtgs_pkg::word_type value
);
   import cdtgs_pkg::*;

   word_type value_ff;
   word_type value_in;

   always_comb begin
      value_in = value_ff;
      if (load_en) begin
         value_in = load_value;
      end else if (shift_en) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: hw/rtl/cdtgs_chain.sv
// Ring of table cells; during a scan every word moves one cell toward the head each cycle.
// Depends on cdtgs_pkg and cdtgs_cell.
module cdtgs_chain (
   input  logic                    clock,
   input  cdtgs_pkg::chain_ctl_type ctl,
   input  cdtgs_pkg::word_type      load_value,
   output cdtgs_pkg::word_type      head_value
);
   import cdtgs_pkg::*;

   word_type cell_value [TABLE_DEPTH];

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      logic hit;
      assign hit = ctl.load && (ctl.load_index == cell_index_type'(k));

      // After a full turn of TABLE_DEPTH shifts every word is back in its own cell.
      cdtgs_cell u_cell (
         .clock      (clock),
         .shift_en   (ctl.shift),
         .load_en    (hit),
         .load_value (load_value),
         .next_value (cell_value[(k + 1) % TABLE_DEPTH]),
         .value      (cell_value[k])
      );
   end

   assign head_value = cell_value[0];

endmodule

// File: hw/rtl/cdt_gaussian_sampler_top.sv
// Top level of the constant-time CDT discrete Gaussian sampler.
// Depends on cdtgs_pkg and cdtgs_chain (which uses cdtgs_cell).

// A load item (req_kind 0) writes one CDF word into the table in the cycle it is
// accepted and gives no result; indexes past the table are dropped. A sample item
// (req_kind 1) keeps busy high while every table entry is scanned, whatever the
// random word or half width: the table words rotate once around the ring of cells
// and the single comparator at its head sees one word a cycle. The result appears
// on rsp_noise_value with rsp_valid high for one cycle right after busy falls; the
// receiver cannot stall it, and a new item may be started in that same cycle.
// Configuration writes are always ready and must be made while the block is idle.
module cdt_gaussian_sampler_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_kind,
   input  logic [cdtgs_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [cdtgs_pkg::WORD_W-1:0]       req_entry_value,
   input  logic [cdtgs_pkg::WORD_W-1:0]       req_random_word,
   output logic                               rsp_valid,
   output logic [cdtgs_pkg::WORD_W-1:0]       rsp_noise_value,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cdtgs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cdtgs_pkg::WORD_W-1:0]       csr_data
);
   import cdtgs_pkg::*;

   state_type      state_ff, state_in;
   cell_index_type step_ff, step_in;
   logic           found_ff, found_in;
   word_type       result_ff, result_in;
   word_type       rnd_ff, rnd_in;
   half_width_type hw_ff, hw_in;
   logic           rsp_valid_ff, rsp_valid_in;
   word_type       rsp_value_ff, rsp_value_in;
   word_type       modulus_ff;
   half_width_type half_width_ff;

   chain_ctl_type  chain_ctl;
   word_type       head_value;
   logic           accept;
   logic [DIFF_W-1:0] diff;
   word_type       offset;
   logic           in_range;
   logic           hit;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= '1;
         half_width_ff <= half_width_type'(MAX_HALF_WIDTH);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODULUS:    modulus_ff    <= csr_data;
            CSR_HALF_WIDTH: half_width_ff <= csr_data[HW_W-1:0];
            default:        ;
         endcase
      end
   end

   cdtgs_chain u_chain (
      .clock      (clock),
      .ctl        (chain_ctl),
      .load_value (req_entry_value),
      .head_value (head_value)
   );

   // Signed distance from the center; a negative one is represented through the modulus.
   assign diff     = {1'b0, step_ff} - DIFF_W'(hw_ff);
   assign offset   = diff[DIFF_W-1]
                     ? modulus_ff + {{(WORD_W-DIFF_W){1'b1}}, diff}
                     : {{(WORD_W-DIFF_W){1'b0}}, diff};
   assign in_range = (step_ff <= {hw_ff, 1'b0});
   assign hit      = !found_ff && in_range && (rnd_ff <= head_value);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      result_in    = result_ff;
      rnd_in       = rnd_ff;
      hw_in        = hw_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      chain_ctl.shift      = 1'b0;
      chain_ctl.load       = 1'b0;
      chain_ctl.load_index = req_entry_index[CNT_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind) begin
                  state_in  = ST_SCAN;
                  step_in   = '0;
                  found_in  = 1'b0;
                  result_in = '0;
                  rnd_in    = req_random_word;
                  hw_in     = (half_width_ff > half_width_type'(MAX_HALF_WIDTH))
                              ? half_width_type'(MAX_HALF_WIDTH) : half_width_ff;
               end else begin
                  chain_ctl.load = (req_entry_index < IDX_W'(TABLE_DEPTH));
               end
            end
         end
         ST_SCAN: begin
            chain_ctl.shift = 1'b1;
            if (hit) begin
               found_in  = 1'b1;
               result_in = offset;
            end
            if (step_ff == LAST_STEP) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_value_in = hit ? offset : result_ff;
            end else begin
               step_in = step_ff + cell_index_type'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff    <= result_in;
      rnd_ff       <= rnd_in;
      hw_ff        <= hw_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   a_rsp_after_last_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_SCAN) && ($past(step_ff) == LAST_STEP))
      else $error("result strobe without a finished scan");

   a_step_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (step_ff != LAST_STEP) |=>
         (state_ff == ST_SCAN) && (step_ff == $past(step_ff) + 1'b1))
      else $error("scan step did not advance");

   a_no_load_in_scan: assert property (@(posedge clock) disable iff (reset)
      !(chain_ctl.load && chain_ctl.shift))
      else $error("table load during rotation");

   a_scan_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (step_ff == LAST_STEP) |=> (state_ff == ST_IDLE) && rsp_valid)
      else $error("scan end did not return to idle with a result");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the constant-time CDT Gaussian sampler top level.
// Depends on cdtgs_pkg and cdt_gaussian_sampler_top; predicts each sample from its own
// CDF table copy and the two configuration registers unless a directed row gives it.
`timescale 1ns / 100ps

module testbench;
   import cdtgs_pkg::*;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;
   localparam int   NUM_ROWS    = 28;
   localparam int   NUM_PHASES  = 8;
   localparam int   PHASE_ITEMS = 145;

   typedef enum {OP_LOAD, OP_SAMPLE, OP_SET_MODULUS, OP_SET_HALF_WIDTH} row_op_type;

   typedef struct {
      row_op_type       op;
      logic [IDX_W-1:0] entry_index;
      word_type         value;
      word_type         random_word;
      bit               exp_given;
      word_type         exp_noise;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_kind = KIND_LOAD;
   logic [IDX_W-1:0]     req_entry_index = '0;
   word_type             req_entry_value = '0;
   word_type             req_random_word = '0;
   logic                 rsp_valid;
   word_type             rsp_noise_value;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MODULUS;
   word_type             csr_data = '0;

   // Mirror of the block state, updated at the edge where each item is accepted.
   word_type       cdf_words [TABLE_DEPTH];
   word_type       cfg_modulus = '1;
   half_width_type cfg_half_width = half_width_type'(MAX_HALF_WIDTH);
   word_type       noise_expected_q [$];
   int             mismatch_count = 0;
   bit             no_gaps = 1'b0;
   stim_row_type   directed_rows [NUM_ROWS];

   cdt_gaussian_sampler_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic word_type rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned effective_half_width();
      return (cfg_half_width > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : int'(cfg_half_width);
   endfunction

   // First entry at or above the random word picks the offset; negatives wrap by modulus.
   function automatic word_type predict_noise(word_type rnd);
      int unsigned span;
      word_type    noise;
      bit          hit;
      span  = effective_half_width();
      noise = '0;
      hit   = 1'b0;
      for (int unsigned i = 0; i <= 2 * span; i++) begin
         if (!hit && rnd <= cdf_words[i]) begin
            hit   = 1'b1;
            noise = (i < span) ? cfg_modulus - word_type'(span - i) : word_type'(i - span);
         end
      end
      return noise;
   endfunction

   // Random words are aimed mostly at table entries and their neighbors.
   function automatic word_type pick_random_word();
      int unsigned pos;
      pos = $urandom_range(2 * effective_half_width());
      case ($urandom_range(7))
         1: return cdf_words[pos] + 1'b1;
         2: return cdf_words[pos] - 1'b1;
         3: return rand64();
         4: return '0;
         5: return '1;
         default: return cdf_words[pos];
      endcase
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 75) return $urandom_range(3, 1);
      if (r < 90) return $urandom_range(20, 4);
      return $urandom_range(140, 120);
   endfunction

   // Entered at a rising edge; returns at the edge where the item is accepted.
   task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                            input word_type value, input word_type rnd,
                            input bit exp_given, input word_type exp_noise);
      int       gap;
      word_type noise_next;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_entry_index <= idx;
      req_entry_value <= value;
      req_random_word <= rnd;
      do @(posedge clock); while (busy !== 1'b0);
      if (kind == KIND_LOAD) begin
         if (idx < TABLE_DEPTH) cdf_words[idx] = value;
      end else begin
         noise_next       = exp_given ? exp_noise : predict_noise(rnd);
         noise_expected_q = {noise_expected_q, noise_next};
      end
   endtask

   // Loads need no result, so a few extra cycles cover a write still in flight.
   task automatic wait_idle();
      start <= 1'b0;
      while (noise_expected_q.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type which, input word_type data);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (which == CSR_MODULUS) cfg_modulus = data;
      else cfg_half_width = data[HW_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A non-decreasing table over the used range, the shape real software loads.
   task automatic load_sorted_table();
      int unsigned span;
      word_type    level;
      span  = effective_half_width();
      level = word_type'($urandom_range(1000));
      for (int unsigned i = 0; i <= 2 * span; i++) begin
         if (i == 2 * span && $urandom_range(1)) level = '1;
         send_item(KIND_LOAD, IDX_W'(i), level, rand64(), 1'b0, '0);
         level = level + (rand64() >> 8);
      end
   endtask

   task automatic send_random_item();
      logic [IDX_W-1:0] idx;
      word_type         value;
      if ($urandom_range(1)) begin
         send_item(KIND_SAMPLE, IDX_W'($urandom), rand64(), pick_random_word(), 1'b0, '0);
      end else begin
         idx = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(TABLE_DEPTH - 1))
                                         : IDX_W'($urandom_range(255, TABLE_DEPTH));
         case ($urandom_range(4))
            0: value = '0;
            1: value = '1;
            default: value = rand64();
         endcase
         send_item(KIND_LOAD, idx, value, rand64(), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      word_type expected_noise;
      if (!reset && rsp_valid === 1'b1) begin
         if (noise_expected_q.size() == 0) begin
            $error("noise_value: no result expected, actual %h", rsp_noise_value);
            mismatch_count++;
         end else begin
            expected_noise = noise_expected_q.pop_front();
            if (rsp_noise_value !== expected_noise) begin
               $error("noise_value: expected %h, actual %h", expected_noise, rsp_noise_value);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      word_type mod_value;
      word_type hw_value;

      // The table starts as entry i = i << 56, so directed results read off directly.
      directed_rows = '{
         '{OP_SAMPLE, 8'd0, '0, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFBF},
         '{OP_SAMPLE, 8'd0, '0, 64'h4000_0000_0000_0000, 1'b1, 64'd0},
         '{OP_SAMPLE, 8'd0, '0, 64'h4000_0000_0000_0001, 1'b1, 64'd1},
         '{OP_SAMPLE, 8'd0, '0, 64'h8000_0000_0000_0000, 1'b1, 64'd64},
         '{OP_SAMPLE, 8'd0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0},
         '{OP_LOAD, 8'd128, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
         '{OP_SAMPLE, 8'd0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd64},
         '{OP_LOAD, 8'd129, 64'h0, 64'h0, 1'b0, '0},
         '{OP_LOAD, 8'd255, 64'h0, 64'h0, 1'b0, '0},
         '{OP_SAMPLE, 8'd0, '0, 64'h0100_0000_0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFC0},
         '{OP_SAMPLE, 8'd0, '0, 64'h7F00_0000_0000_0000, 1'b1, 64'd63},
         '{OP_LOAD, 8'd0, 64'd5, 64'h0, 1'b0, '0},
         '{OP_SAMPLE, 8'd0, '0, 64'd5, 1'b1, 64'hFFFF_FFFF_FFFF_FFBF},
         '{OP_SAMPLE, 8'd0, '0, 64'd6, 1'b1, 64'hFFFF_FFFF_FFFF_FFC0},
         '{OP_SAMPLE, 8'd3, 64'h0, 64'h0300_0000_0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFC2},
         '{OP_SAMPLE, 8'd0, '0, 64'h0300_0000_0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFC2},
         '{OP_SET_HALF_WIDTH, 8'd0, 64'd0, '0, 1'b0, '0},
         '{OP_SAMPLE, 8'd0, '0, 64'd5, 1'b1, 64'd0},
         '{OP_SAMPLE, 8'd0, '0, 64'd6, 1'b1, 64'd0},
         '{OP_SET_HALF_WIDTH, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
         '{OP_SAMPLE, 8'd0, '0, 64'h0100_0000_0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFC0},
         '{OP_SET_HALF_WIDTH, 8'd0, 64'h8000_0000_0000_0081, '0, 1'b0, '0},
         '{OP_SET_MODULUS, 8'd0, 64'd0, '0, 1'b0, '0},
         '{OP_SAMPLE, 8'd0, '0, 64'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
         '{OP_SAMPLE, 8'd0, '0, 64'h0200_0000_0000_0000, 1'b1, 64'd1},
         '{OP_SET_MODULUS, 8'd0, 64'd1, '0, 1'b0, '0},
         '{OP_SAMPLE, 8'd0, '0, 64'd1, 1'b1, 64'd0},
         '{OP_SAMPLE, 8'd0, '0, 64'h0123_4567_89AB_CDEF, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every entry is written before the first sample scans the table.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_item(KIND_LOAD, IDX_W'(i), word_type'(i) << 56, rand64(), 1'b0, '0);
      end

      foreach (directed_rows[r]) begin
         case (directed_rows[r].op)
            OP_LOAD, OP_SAMPLE: begin
               send_item((directed_rows[r].op == OP_SAMPLE) ? KIND_SAMPLE : KIND_LOAD,
                         directed_rows[r].entry_index, directed_rows[r].value,
                         directed_rows[r].random_word, directed_rows[r].exp_given,
                         directed_rows[r].exp_noise);
            end
            OP_SET_MODULUS: begin
               wait_idle();
               write_csr(CSR_MODULUS, directed_rows[r].value);
            end
            default: begin
               wait_idle();
               write_csr(CSR_HALF_WIDTH, directed_rows[r].value);
            end
         endcase
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin mod_value = '1;       hw_value = 64'd64; end
            1: begin mod_value = rand64(); hw_value = 64'd1; end
            2: begin mod_value = '0;       hw_value = 64'd0; end
            3: begin mod_value = rand64(); hw_value = rand64() | 64'h7F; end
            4: begin mod_value = 64'd1;    hw_value = 64'd32; end
            5: begin
               mod_value = 64'h8000_0000_0000_0000;
               hw_value  = (rand64() & ~64'h7F) | 64'd64;
            end
            6: begin mod_value = rand64(); hw_value = rand64(); end
            default: begin
               mod_value = rand64();
               hw_value  = word_type'($urandom_range(MAX_HALF_WIDTH, 1));
            end
         endcase
         no_gaps = (p % 4 == 2);
         wait_idle();
         if ($urandom_range(1)) begin
            write_csr(CSR_MODULUS, mod_value);
            write_csr(CSR_HALF_WIDTH, hw_value);
         end else begin
            write_csr(CSR_HALF_WIDTH, hw_value);
            write_csr(CSR_MODULUS, mod_value);
         end
         if (p == 0 || $urandom_range(2) != 0) load_sorted_table();
         repeat (PHASE_ITEMS) send_random_item();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && noise_expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
